// ===== hw/rtl/prac_pkg.sv =====
package prac_pkg;

    // Fixed widths of the stream fields
    localparam int IN_COORD_W    = 24;
    localparam int AREA_W        = 64;
    localparam int S_TDATA_W     = 48;
    localparam int M_TDATA_W     = 64;
    localparam int M_TUSER_W     = 2;

    // Defaults for the top-level parameters
    localparam int COORD_BITS_DEF  = 24;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Vertices needed before a ring has any area
    localparam logic [1:0] CNT_FULL = 2'd3;

    localparam logic [AREA_W-1:0] SUM_MAX = {1'b0, {(AREA_W-1){1'b1}}};
    localparam logic [AREA_W-1:0] SUM_MIN = {1'b1, {(AREA_W-1){1'b0}}};

    // tuser bit positions on the result side
    localparam int TUSER_SHORT = 0;
    localparam int TUSER_SAT   = 1;

    // What the back end does with one queued vertex
    typedef struct packed {
        logic acc;        // add this vertex's cross term
        logic last;       // final vertex: emit and clear
        logic short_ring; // ring ended with fewer than three vertices
    } t_op_flags;

    localparam int FLAGS_W = $bits(t_op_flags);

endpackage

// ===== hw/rtl/prac_front.sv =====
module prac_front #(
    parameter int COORD_BITS = prac_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // point_x [23:0], point_y [47:24]
    input  logic [prac_pkg::S_TDATA_W-1:0]    i_tdata,
    input  logic                              i_tlast,
    input  logic                              i_accept,
    output logic signed [COORD_BITS:0]        o_dx,
    output logic signed [COORD_BITS:0]        o_dy,
    output prac_pkg::t_op_flags               o_flags
);

    logic signed [COORD_BITS-1:0] w_x;
    logic signed [COORD_BITS-1:0] w_y;

    logic signed [COORD_BITS-1:0] r_first_x, n_first_x;
    logic signed [COORD_BITS-1:0] r_last_x,  n_last_x;
    logic signed [COORD_BITS-1:0] r_last_y,  n_last_y;
    logic signed [COORD_BITS-1:0] r_older_y, n_older_y;
    logic [1:0]                   r_count,   n_count;

    // Low COORD_BITS of each field, sign taken from the top kept bit
    assign w_x = COORD_BITS'(i_tdata[prac_pkg::IN_COORD_W-1:0]);
    assign w_y = COORD_BITS'(i_tdata[prac_pkg::S_TDATA_W-1:prac_pkg::IN_COORD_W]);

    assign o_dx = {r_last_x[COORD_BITS-1], r_last_x} - {r_first_x[COORD_BITS-1], r_first_x};
    assign o_dy = {r_older_y[COORD_BITS-1], r_older_y} - {w_y[COORD_BITS-1], w_y};

    always_comb begin
        o_flags            = '0;
        o_flags.acc        = r_count[1];
        o_flags.last       = i_tlast;
        o_flags.short_ring = !r_count[1];
    end

    always_comb begin
        n_first_x = r_first_x;
        n_last_x  = r_last_x;
        n_last_y  = r_last_y;
        n_older_y = r_older_y;
        n_count   = r_count;
        if (i_accept) begin
            if (i_tlast) begin
                // clear ring state for the next ring
                n_first_x = '0;
                n_last_x  = '0;
                n_last_y  = '0;
                n_older_y = '0;
                n_count   = '0;
            end else begin
                if (r_count == 2'd0) begin
                    n_first_x = w_x;
                end
                n_older_y = r_last_y;
                n_last_y  = w_y;
                n_last_x  = w_x;
                if (r_count != prac_pkg::CNT_FULL) begin
                    n_count = r_count + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_x <= '0;
            r_last_x  <= '0;
            r_last_y  <= '0;
            r_older_y <= '0;
            r_count   <= '0;
        end else begin
            r_first_x <= n_first_x;
            r_last_x  <= n_last_x;
            r_last_y  <= n_last_y;
            r_older_y <= n_older_y;
            r_count   <= n_count;
        end
    end

endmodule

// ===== hw/rtl/prac_queue.sv =====
module prac_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = prac_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_MAX);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("queue count beyond depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("queue count missed a push");

endmodule

// ===== hw/rtl/prac_back.sv =====
module prac_back #(
    parameter int COORD_BITS = prac_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_abs_mode,
    // queue head
    input  logic                              i_q_valid,
    input  logic signed [COORD_BITS:0]        i_dx,
    input  logic signed [COORD_BITS:0]        i_dy,
    input  prac_pkg::t_op_flags               i_flags,
    output logic                              o_q_pop,
    // result stream
    output logic                              o_tvalid,
    input  logic                              i_tready,
    // twice_area [63:0]
    output logic [prac_pkg::M_TDATA_W-1:0]    o_tdata,
    // short_ring [0], saturated [1]
    output logic [prac_pkg::M_TUSER_W-1:0]    o_tuser
);

    localparam int PROD_W = 2 * COORD_BITS + 2;
    localparam int AW     = prac_pkg::AREA_W;

    // multiply stage
    logic                       r_m_vld;
    logic signed [PROD_W-1:0]   r_prod;
    prac_pkg::t_op_flags        r_m_flags;

    // accumulator
    logic [AW-1:0]              r_sum, n_sum;
    logic                       r_clip, n_clip;

    // finished ring waiting for the magnitude stage
    logic                       r_fin_vld;
    logic [AW-1:0]              r_fin_sum, n_fin_sum;
    logic                       r_fin_sat, n_fin_sat;
    logic                       r_fin_short;

    // output register
    logic                       r_out_vld;
    logic [AW-1:0]              r_out_data, n_out_data;
    logic                       r_out_sat,  n_out_sat;
    logic                       r_out_short;

    logic                       w_out_free;
    logic                       w_fin_ready;
    logic                       w_m_ready;
    logic                       w_adv_acc;
    logic [AW-1:0]              w_term;
    logic [AW-1:0]              w_add;
    logic                       w_ovf;
    logic [AW-1:0]              w_sum_new;
    logic                       w_clip_new;

    assign w_out_free  = !r_out_vld || i_tready;
    assign w_fin_ready = !r_fin_vld || w_out_free;
    assign w_m_ready   = !r_m_vld || w_fin_ready;
    assign w_adv_acc   = r_m_vld && w_fin_ready;
    assign o_q_pop     = i_q_valid && w_m_ready;

    assign o_tvalid = r_out_vld;
    assign o_tdata  = r_out_data;
    always_comb begin
        o_tuser = '0;
        o_tuser[prac_pkg::TUSER_SHORT] = r_out_short;
        o_tuser[prac_pkg::TUSER_SAT]   = r_out_sat;
    end

    // Saturating accumulate
    assign w_term = {{(AW - PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign w_add  = r_sum + w_term;
    assign w_ovf  = (r_sum[AW-1] == w_term[AW-1]) && (w_add[AW-1] != r_sum[AW-1]);

    always_comb begin
        w_sum_new  = r_sum;
        w_clip_new = r_clip;
        if (r_m_flags.acc) begin
            if (w_ovf) begin
                w_sum_new  = w_term[AW-1] ? prac_pkg::SUM_MIN : prac_pkg::SUM_MAX;
                w_clip_new = 1'b1;
            end else begin
                w_sum_new = w_add;
            end
        end
    end

    always_comb begin
        n_sum     = r_sum;
        n_clip    = r_clip;
        n_fin_sum = r_fin_sum;
        n_fin_sat = r_fin_sat;
        if (w_adv_acc) begin
            if (r_m_flags.last) begin
                n_fin_sum = r_m_flags.short_ring ? '0 : w_sum_new;
                n_fin_sat = r_m_flags.short_ring ? 1'b0 : w_clip_new;
                // drop the ring's sum once it is handed on
                n_sum     = '0;
                n_clip    = 1'b0;
            end else begin
                n_sum  = w_sum_new;
                n_clip = w_clip_new;
            end
        end
    end

    // Magnitude stage
    always_comb begin
        n_out_data = r_fin_sum;
        n_out_sat  = r_fin_sat;
        if (i_abs_mode && r_fin_sum[AW-1]) begin
            if (r_fin_sum == prac_pkg::SUM_MIN) begin
                n_out_data = prac_pkg::SUM_MAX;
                n_out_sat  = 1'b1;
            end else begin
                n_out_data = -r_fin_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_prod    <= i_dx * i_dy;
            r_m_flags <= i_flags;
        end
        if (w_adv_acc && r_m_flags.last) begin
            r_fin_sum   <= n_fin_sum;
            r_fin_sat   <= n_fin_sat;
            r_fin_short <= r_m_flags.short_ring;
        end
        if (r_fin_vld && w_out_free) begin
            r_out_data  <= n_out_data;
            r_out_sat   <= n_out_sat;
            r_out_short <= r_fin_short;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld   <= 1'b0;
            r_fin_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_sum     <= '0;
            r_clip    <= 1'b0;
        end else begin
            r_sum  <= n_sum;
            r_clip <= n_clip;
            if (w_m_ready) begin
                r_m_vld <= i_q_valid;
            end
            if (w_fin_ready) begin
                r_fin_vld <= w_adv_acc && r_m_flags.last;
            end
            if (w_out_free) begin
                r_out_vld <= r_fin_vld;
            end
        end
    end

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv_acc && r_m_flags.last |=> r_sum == '0 && !r_clip)
        else $error("accumulator not cleared after ring end");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_vld && r_fin_short |-> r_fin_sum == '0 && !r_fin_sat)
        else $error("short ring carries area or clip");

    a_no_acc_on_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_vld && r_m_flags.short_ring |-> !r_m_flags.acc)
        else $error("short-ring vertex marked for accumulation");

endmodule

// ===== hw/rtl/polygon_ring_area_core.sv =====
// A result is registered after the vertex carrying tlast is transferred, passing through
// the queue, multiply register, accumulate register and magnitude/output register.
// Throughput: one vertex per cycle, set by the pipelined multiply-accumulate, while
// the 4-entry queue has room; it takes vertices while a result waits on m_tready.
// Reset (i_rst_n low, synchronous): ring state, accumulator and queue clear,
// absolute mode returns to 0, no result is pending; no clearing pass is needed.
module polygon_ring_area_core #(
    parameter int COORD_BITS  = prac_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = prac_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration: absolute_mode [0]
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [0:0]                        i_cfg_data,
    // vertex stream: point_x [23:0], point_y [47:24]; tlast = ring_end
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [prac_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,
    // result stream: twice_area [63:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [prac_pkg::M_TDATA_W-1:0]    m_tdata,
    // short_ring [0], saturated [1]
    output logic [prac_pkg::M_TUSER_W-1:0]    m_tuser
);

    localparam int FW = COORD_BITS + 1;
    localparam int QW = 2 * FW + prac_pkg::FLAGS_W;

    logic                     r_abs_mode;
    logic                     w_accept;
    logic                     w_q_full;
    logic                     w_q_empty;
    logic                     w_q_pop;
    logic signed [FW-1:0]     w_f_dx;
    logic signed [FW-1:0]     w_f_dy;
    prac_pkg::t_op_flags      w_f_flags;
    logic [QW-1:0]            w_q_in;
    logic [QW-1:0]            w_q_out;
    logic signed [FW-1:0]     w_b_dx;
    logic signed [FW-1:0]     w_b_dy;
    prac_pkg::t_op_flags      w_b_flags;

    assign o_cfg_ready = 1'b1;
    assign s_tready    = !w_q_full;
    assign w_accept    = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_abs_mode <= i_cfg_data[0];
        end
    end

    prac_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tdata  (s_tdata),
        .i_tlast  (s_tlast),
        .i_accept (w_accept),
        .o_dx     (w_f_dx),
        .o_dy     (w_f_dy),
        .o_flags  (w_f_flags)
    );

    assign w_q_in = {w_f_flags, w_f_dy, w_f_dx};

    prac_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_data  (w_q_out)
    );

    assign w_b_dx    = w_q_out[FW-1:0];
    assign w_b_dy    = w_q_out[2*FW-1:FW];
    assign w_b_flags = w_q_out[QW-1:2*FW];

    prac_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_abs_mode (r_abs_mode),
        .i_q_valid  (!w_q_empty),
        .i_dx       (w_b_dx),
        .i_dy       (w_b_dy),
        .i_flags    (w_b_flags),
        .o_q_pop    (w_q_pop),
        .o_tvalid   (m_tvalid),
        .i_tready   (m_tready),
        .o_tdata    (m_tdata),
        .o_tuser    (m_tuser)
    );

endmodule
